// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/mmc3x_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc3x_pkg
// Shared types, codes and decode helpers of the extended MMC3 bank mapper.
// ----------------------------------------------------------------------------
package mmc3x_pkg;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_CHR   = 2'd1,
		FUNC_PRG   = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
	localparam logic [15:0] REG_SELECT      = 16'h8000;
	localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
	localparam logic [15:0] REG_MIRROR      = 16'hA000;

	localparam logic [7:0] PRG_RESET_2 = 8'h3E;
	localparam logic [7:0] PRG_RESET_3 = 8'h3F;
	localparam logic [7:0] CHR_RAM_TOP = 8'h07;

	typedef enum logic {
		ST_EMPTY = 1'b0,
		ST_FULL  = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic       chr_en;
		logic       prg_en;
		logic [2:0] idx;
	} bank_tgt_t;

	// Map the low select nibble to the bank register it writes.
	function automatic bank_tgt_t bank_target(input logic [3:0] code);
		bank_tgt_t t;
		t = '{chr_en: 1'b0, prg_en: 1'b0, idx: 3'd0};
		case (code)
			4'h0: t = '{chr_en: 1'b1, prg_en: 1'b0, idx: 3'd0};
			4'h1: t = '{chr_en: 1'b1, prg_en: 1'b0, idx: 3'd2};
			4'h2: t = '{chr_en: 1'b1, prg_en: 1'b0, idx: 3'd4};
			4'h3: t = '{chr_en: 1'b1, prg_en: 1'b0, idx: 3'd5};
			4'h4: t = '{chr_en: 1'b1, prg_en: 1'b0, idx: 3'd6};
			4'h5: t = '{chr_en: 1'b1, prg_en: 1'b0, idx: 3'd7};
			4'h6: t = '{chr_en: 1'b0, prg_en: 1'b1, idx: 3'd0};
			4'h7: t = '{chr_en: 1'b0, prg_en: 1'b1, idx: 3'd1};
			4'h8: t = '{chr_en: 1'b0, prg_en: 1'b1, idx: 3'd2};
			4'h9: t = '{chr_en: 1'b0, prg_en: 1'b1, idx: 3'd3};
			4'hA: t = '{chr_en: 1'b1, prg_en: 1'b0, idx: 3'd1};
			4'hB: t = '{chr_en: 1'b1, prg_en: 1'b0, idx: 3'd3};
			default: t = '{chr_en: 1'b0, prg_en: 1'b0, idx: 3'd0};
		endcase
		return t;
	endfunction

endpackage

// ===== hw/rtl/mmc3x_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc3x_ctrl
// Handshake controller: tracks the output register and issues load commands.
// ----------------------------------------------------------------------------
module mmc3x_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output mmc3x_pkg::dp_cmd_t cmd
);

	mmc3x_pkg::ctrl_state_t state_q, state_nxt;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmc3x_pkg::ST_EMPTY;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign accept = in_valid && !in_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mmc3x_pkg::ST_EMPTY: begin
				if (accept) begin
					state_nxt = mmc3x_pkg::ST_FULL;
				end
			end
			mmc3x_pkg::ST_FULL: begin
				// drain when taken and nothing new arrives
				if (!out_stall && !accept) begin
					state_nxt = mmc3x_pkg::ST_EMPTY;
				end
			end
			default: state_nxt = mmc3x_pkg::ST_EMPTY;
		endcase
	end

	always_comb begin
		out_valid = 1'b0;
		in_stall  = 1'b0;
		case (state_q)
			mmc3x_pkg::ST_EMPTY: begin
				out_valid = 1'b0;
				in_stall  = 1'b0;
			end
			mmc3x_pkg::ST_FULL: begin
				out_valid = 1'b1;
				in_stall  = out_stall;
			end
			default: begin
				out_valid = 1'b0;
				in_stall  = 1'b1;
			end
		endcase
		cmd.load = in_valid && !in_stall;
	end

endmodule

// ===== hw/rtl/mmc3x_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc3x_dp
// Mapper datapath: bank registers, lookup logic and the result register.
// ----------------------------------------------------------------------------
module mmc3x_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  mmc3x_pkg::dp_cmd_t cmd,
	input  logic [1:0]         func,
	input  logic [15:0]        addr,
	input  logic [7:0]         data,
	output logic [7:0]         bank,
	output logic               chr_ram,
	output logic [1:0]         mirroring,
	output logic [2:0]         slot
);

	logic [7:0] select_q;
	logic [7:0] chr_banks_q [8];
	logic [7:0] prg_banks_q [4];
	logic [1:0] mirror_q;

	logic [7:0]  bank_q;
	logic        chr_ram_q;
	logic [1:0]  mirroring_q;
	logic [2:0]  slot_q;

	mmc3x_pkg::func_t     fn;
	mmc3x_pkg::bank_tgt_t tgt;
	logic [15:0] reg_addr;
	logic        wr_select, wr_bank, wr_mirror;
	logic [2:0]  chr_idx;
	logic [1:0]  prg_idx;
	logic [7:0]  bank_nxt;
	logic        chr_ram_nxt;
	logic [1:0]  mirror_nxt;
	logic [2:0]  slot_nxt;

	always_comb begin
		fn        = mmc3x_pkg::func_t'(func);
		reg_addr  = addr & mmc3x_pkg::REG_DECODE_MASK;
		wr_select = (fn == mmc3x_pkg::FUNC_WRITE) && (reg_addr == mmc3x_pkg::REG_SELECT);
		wr_bank   = (fn == mmc3x_pkg::FUNC_WRITE) && (reg_addr == mmc3x_pkg::REG_BANK_DATA);
		wr_mirror = (fn == mmc3x_pkg::FUNC_WRITE) && (reg_addr == mmc3x_pkg::REG_MIRROR);
		tgt       = mmc3x_pkg::bank_target(select_q[3:0]);
		// select bit 7 swaps the CHR halves, bit 6 swaps the PRG slots at 8000/C000
		chr_idx   = addr[12:10] ^ {select_q[7], 2'b00};
		prg_idx   = {addr[14] ^ (select_q[6] & ~addr[13]), addr[13]};
		mirror_nxt = wr_mirror ? data[1:0] : mirror_q;

		bank_nxt    = 8'd0;
		chr_ram_nxt = 1'b0;
		slot_nxt    = 3'd0;
		case (fn)
			mmc3x_pkg::FUNC_CHR: begin
				bank_nxt    = chr_banks_q[chr_idx];
				chr_ram_nxt = (chr_banks_q[chr_idx] <= mmc3x_pkg::CHR_RAM_TOP);
				slot_nxt    = addr[12:10];
			end
			mmc3x_pkg::FUNC_PRG: begin
				bank_nxt = prg_banks_q[prg_idx];
				slot_nxt = addr[15:13];
			end
			default: begin
				bank_nxt    = 8'd0;
				chr_ram_nxt = 1'b0;
				slot_nxt    = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q <= 8'd0;
			mirror_q <= 2'd0;
			for (int i = 0; i < 8; i++) begin
				chr_banks_q[i] <= 8'(i);
			end
			prg_banks_q[0] <= 8'h00;
			prg_banks_q[1] <= 8'h01;
			prg_banks_q[2] <= mmc3x_pkg::PRG_RESET_2;
			prg_banks_q[3] <= mmc3x_pkg::PRG_RESET_3;
		end else if (cmd.load) begin
			if (wr_select) begin
				select_q <= data;
			end
			if (wr_bank && tgt.chr_en) begin
				chr_banks_q[tgt.idx] <= data;
			end
			if (wr_bank && tgt.prg_en) begin
				prg_banks_q[tgt.idx[1:0]] <= data;
			end
			mirror_q <= mirror_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bank_q      <= bank_nxt;
			chr_ram_q   <= chr_ram_nxt;
			mirroring_q <= mirror_nxt;
			slot_q      <= slot_nxt;
		end
	end

	assign bank      = bank_q;
	assign chr_ram   = chr_ram_q;
	assign mirroring = mirroring_q;
	assign slot      = slot_q;

endmodule

// ===== hw/rtl/mmc3_extended_bank_mapper_unit.sv =====
`timescale 1ns / 1ps
// An accepted transaction's result appears on the outputs in the next cycle.
// Throughput: one transaction per cycle unless the consumer stalls; the lookup and
// register update finish in the accept cycle and the result register frees the input side.
// Reset (arst_n low): select 0, CHR banks 0..7, PRG banks 0, 1, 3E, 3F,
// mirroring 0, output register empty.
// ----------------------------------------------------------------------------
// mmc3_extended_bank_mapper_unit
// MMC3-style bank mapper with eight 1K CHR and four 8K PRG bank registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmc3_extended_bank_mapper_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [15:0] addr,
	input  logic [7:0]  data,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  bank,
	output logic        chr_ram,
	output logic [1:0]  mirroring,
	output logic [2:0]  slot
);

	// Load command from the controller: capture the transaction and update state.
	mmc3x_pkg::dp_cmd_t cmd;

	// Accepted write that lands on the mirroring register.
	logic mirror_wr;

	// Controller: hold the result while the consumer stalls; stall the input
	// only when the result register is full and not being taken.
	mmc3x_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Datapath: decode writes at 8000/8001/A000, look up CHR and PRG banks,
	// and register the result for the output channel.
	mmc3x_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.func      (func),
		.addr      (addr),
		.data      (data),
		.bank      (bank),
		.chr_ram   (chr_ram),
		.mirroring (mirroring),
		.slot      (slot)
	);

	assign mirror_wr = in_valid && !in_stall && (func == mmc3x_pkg::FUNC_WRITE)
		&& ((addr & mmc3x_pkg::REG_DECODE_MASK) == mmc3x_pkg::REG_MIRROR);

	// The input side may only stall behind a pending result.
	`ASSERT_IMPL(a_stall_needs_result, clk, arst_n, in_stall, out_valid)

	// Every accepted transaction shows a result in the next cycle.
	`ASSERT_NEXT(a_accept_gives_result, clk, arst_n, in_valid && !in_stall, out_valid)

	// A mirroring write reports the new mode in its own result.
	`ASSERT_NEXT(a_mirror_write, clk, arst_n, mirror_wr, mirroring == $past(data[1:0]))

endmodule

// ===== verif/bank_map_tracker_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_map_tracker_pkg
// Transaction types and a tracker that mirrors the mapper's bank registers,
// predicts each lookup and checks results in order.
// ----------------------------------------------------------------------------
package bank_map_tracker_pkg;
	import mmc3x_pkg::*;

	// Low select nibble: which bank register an odd 0x8000 write updates.
	localparam logic [3:0] SEL_CHR0 = 4'h0;
	localparam logic [3:0] SEL_CHR2 = 4'h1;
	localparam logic [3:0] SEL_CHR4 = 4'h2;
	localparam logic [3:0] SEL_CHR5 = 4'h3;
	localparam logic [3:0] SEL_CHR6 = 4'h4;
	localparam logic [3:0] SEL_CHR7 = 4'h5;
	localparam logic [3:0] SEL_PRG0 = 4'h6;
	localparam logic [3:0] SEL_PRG1 = 4'h7;
	localparam logic [3:0] SEL_PRG2 = 4'h8;
	localparam logic [3:0] SEL_PRG3 = 4'h9;
	localparam logic [3:0] SEL_CHR1 = 4'hA;
	localparam logic [3:0] SEL_CHR3 = 4'hB;
	localparam logic [3:0] SEL_NONE = 4'hC;

	typedef struct packed {
		func_t       func;
		logic [15:0] addr;
		logic [7:0]  data;
	} map_request_t;

	typedef struct packed {
		logic [7:0] bank;
		logic       chr_ram;
		logic [1:0] mirroring;
		logic [2:0] slot;
	} map_result_t;

	class bank_map_tracker;
		logic [7:0]  bank_sel;
		logic [7:0]  chr_bank[8];
		logic [7:0]  prg_bank[4];
		logic [1:0]  mirror;
		map_result_t pending_maps[$];
		int unsigned errors;

		function new();
			bank_sel = '0;
			for (int i = 0; i < 8; i++)
				chr_bank[i] = i[7:0];
			prg_bank[0] = 8'h00;
			prg_bank[1] = 8'h01;
			prg_bank[2] = PRG_RESET_2;
			prg_bank[3] = PRG_RESET_3;
			mirror = '0;
			errors = 0;
		endfunction

		function void write_selected(logic [7:0] value);
			case (bank_sel[3:0])
				SEL_CHR0: chr_bank[0] = value;
				SEL_CHR1: chr_bank[1] = value;
				SEL_CHR2: chr_bank[2] = value;
				SEL_CHR3: chr_bank[3] = value;
				SEL_CHR4: chr_bank[4] = value;
				SEL_CHR5: chr_bank[5] = value;
				SEL_CHR6: chr_bank[6] = value;
				SEL_CHR7: chr_bank[7] = value;
				SEL_PRG0: prg_bank[0] = value;
				SEL_PRG1: prg_bank[1] = value;
				SEL_PRG2: prg_bank[2] = value;
				SEL_PRG3: prg_bank[3] = value;
				default: ;
			endcase
		endfunction

		// Apply one accepted request and queue the result it must produce.
		function void note_request(map_request_t req);
			map_result_t exp;
			logic [2:0]  chr_idx;
			logic [1:0]  prg_idx;
			exp = '0;
			case (req.func)
				FUNC_WRITE: begin
					case (req.addr & REG_DECODE_MASK)
						REG_SELECT:    bank_sel = req.data;
						REG_BANK_DATA: write_selected(req.data);
						REG_MIRROR:    mirror = req.data[1:0];
						default: ;
					endcase
				end
				FUNC_CHR: begin
					// select bit 7 swaps the two 4K halves
					exp.slot = req.addr[12:10];
					chr_idx = req.addr[12:10] ^ {bank_sel[7], 2'b00};
					exp.bank = chr_bank[chr_idx];
					exp.chr_ram = (exp.bank <= CHR_RAM_TOP);
				end
				FUNC_PRG: begin
					// select bit 6 swaps the 0x8000 and 0xC000 slots
					exp.slot = req.addr[15:13];
					prg_idx = req.addr[14:13] ^ {bank_sel[6] & ~req.addr[13], 1'b0};
					exp.bank = prg_bank[prg_idx];
				end
				default: ;
			endcase
			exp.mirroring = mirror;
			pending_maps.push_back(exp);
		endfunction

		function void compare_field(string name, logic [7:0] exp, logic [7:0] got);
			if (got !== exp) begin
				$display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, exp, got);
				errors++;
			end
		endfunction

		function void check_result(map_result_t got);
			map_result_t exp;
			if (pending_maps.size() == 0) begin
				$display("%0t ns: unexpected result: expected none, actual %p", $time, got);
				errors++;
				return;
			end
			exp = pending_maps.pop_front();
			compare_field("bank", exp.bank, got.bank);
			compare_field("chr_ram", {7'd0, exp.chr_ram}, {7'd0, got.chr_ram});
			compare_field("mirroring", {6'd0, exp.mirroring}, {6'd0, got.mirroring});
			compare_field("slot", {5'd0, exp.slot}, {5'd0, got.slot});
		endfunction

		function int unsigned pending();
			return pending_maps.size();
		endfunction
	endclass

endpackage

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives register writes, CHR and PRG lookups and no-op transactions into the
// bank mapper under random sender gaps and receiver stalls, and checks every
// result against a tracked copy of the mapper's bank registers.
// ----------------------------------------------------------------------------
module tb;
	import mmc3x_pkg::*;
	import bank_map_tracker_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASE_ITEMS = 262;
	localparam int unsigned HOLD_CYCLES = 40;
	localparam int unsigned TAIL_CYCLES = 4;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = '0;
	logic [15:0] addr = '0;
	logic [7:0]  data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  bank;
	logic        chr_ram;
	logic [1:0]  mirroring;
	logic [2:0]  slot;

	// Idle percentages per phase, read by the driver and the receiver.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          long_hold = 1'b0;
	int unsigned cycle_count = 0;

	bank_map_tracker tracker = new();

	mmc3_extended_bank_mapper_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.addr     (addr),
		.data     (data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bank     (bank),
		.chr_ram  (chr_ram),
		.mirroring(mirroring),
		.slot     (slot)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: end the run if the handshakes never finish.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: stall at random, or hold off for a long stretch on request so
	// the mapper backs up and stalls its input.
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Monitor both channels at the edge, before any register in the block moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_result('{bank: bank, chr_ram: chr_ram,
					mirroring: mirroring, slot: slot});
			if (in_valid && !in_stall)
				tracker.note_request('{func: func_t'(func), addr: addr, data: data});
		end
	end

	// Offer one transaction, idling first at the phase's rate; return at the
	// edge where it is accepted, with valid still high.
	task automatic send_request(input map_request_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= req.func;
		addr <= req.addr;
		data <= req.data;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_fields(input func_t f, input logic [15:0] a, input logic [7:0] d);
		send_request('{func: f, addr: a, data: d});
	endtask

	// Drop valid and hold until every expected result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	function automatic map_request_t random_request();
		map_request_t r;
		int unsigned  pick;
		pick = $urandom_range(99);
		r.addr = 16'($urandom_range(16'hFFFF));
		r.data = 8'($urandom_range(8'hFF));
		if (pick < 30) begin
			r.func = FUNC_WRITE;
			// mostly hit the decoded registers, otherwise any address
			if ($urandom_range(4) != 0)
				r.addr[15:14] = 2'b10;
			if ($urandom_range(1))
				r.data = 8'($urandom_range(15));
		end else if (pick < 62) begin
			r.func = FUNC_CHR;
		end else if (pick < 95) begin
			r.func = FUNC_PRG;
		end else begin
			r.func = FUNC_NOP;
		end
		return r;
	endfunction

	// A select write followed by a bank write: the sequence that actually
	// moves a bank register.
	task automatic send_bank_update();
		logic [7:0]  sel;
		logic [15:0] a;
		sel = 8'($urandom_range(8'hFF));
		if ($urandom_range(4) != 0)
			sel[3:0] = 4'($urandom_range(SEL_CHR3));
		a = 16'($urandom_range(16'hFFFF));
		a[15:13] = 3'b100;
		a[0] = 1'b0;
		send_fields(FUNC_WRITE, a, sel);
		a = 16'($urandom_range(16'hFFFF));
		a[15:13] = 3'b100;
		a[0] = 1'b1;
		send_fields(FUNC_WRITE, a, $urandom_range(1) ? 8'($urandom_range(15))
			: 8'($urandom_range(8'hFF)));
	endtask

	task automatic run_directed();
		// reset contents in PRG slots 0, 3, 4, 5, 6, 7 and CHR slots 0 and 7, with wrapping addresses
		send_fields(FUNC_PRG, 16'h8000, 8'h00);
		send_fields(FUNC_PRG, 16'hA000, 8'hFF);
		send_fields(FUNC_PRG, 16'hC000, 8'h00);
		send_fields(FUNC_PRG, 16'hFFFF, 8'h00);
		send_fields(FUNC_PRG, 16'h0000, 8'h00);
		send_fields(FUNC_PRG, 16'h7FFF, 8'h00);
		send_fields(FUNC_CHR, 16'h0000, 8'h00);
		send_fields(FUNC_CHR, 16'h1C00, 8'h00);
		send_fields(FUNC_CHR, 16'hFFFF, 8'h00);
		send_fields(FUNC_NOP, 16'hFFFF, 8'hFF);
		// both inversion bits set, PRG slot 0 loaded with the top value
		send_fields(FUNC_WRITE, REG_SELECT, {2'b11, 2'b00, SEL_PRG0});
		send_fields(FUNC_WRITE, REG_BANK_DATA, 8'hFF);
		send_fields(FUNC_PRG, 16'h8000, 8'h00);
		send_fields(FUNC_PRG, 16'hC000, 8'h00);
		send_fields(FUNC_CHR, 16'h0000, 8'h00);
		// unused select code leaves every bank alone
		send_fields(FUNC_WRITE, REG_SELECT, {4'h0, SEL_NONE});
		send_fields(FUNC_WRITE, REG_BANK_DATA, 8'h55);
		// mirroring writes, including the ignored decodes
		send_fields(FUNC_WRITE, REG_MIRROR, 8'hFF);
		send_fields(FUNC_WRITE, 16'hA001, 8'h01);
		send_fields(FUNC_WRITE, 16'hC000, 8'h01);
		send_fields(FUNC_WRITE, 16'h7FFE, 8'h01);
		send_fields(FUNC_WRITE, 16'hBFFE, 8'h02);
		// CHR RAM boundary through mirrored register addresses
		send_fields(FUNC_WRITE, 16'h9FFE, {4'h0, SEL_CHR2});
		send_fields(FUNC_WRITE, 16'h9FFF, 8'h08);
		send_fields(FUNC_CHR, 16'h0800, 8'h00);
		send_fields(FUNC_WRITE, 16'h9FFF, CHR_RAM_TOP);
		send_fields(FUNC_CHR, 16'h0BFF, 8'h00);
	endtask

	initial begin
		int unsigned idle_pct[4];
		int unsigned stall_pct[4];
		int unsigned sent;
		bit          hold_done;
		idle_pct  = '{0, 58, 0, 26};
		stall_pct = '{0, 0, 58, 26};
		hold_done = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_pct[p];
			recv_stall_pct = stall_pct[p];
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// back the block up once while the sender keeps offering
				if (p == 0 && sent >= 40 && !hold_done) begin
					long_hold = 1'b1;
					hold_done = 1'b1;
				end
				if ($urandom_range(99) < 35) begin
					send_bank_update();
					sent += 2;
				end else begin
					send_request(random_request());
					sent += 1;
				end
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
